// File: rtl/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Widths, codes and shared types of the swept sphere collision block.
// ----------------------------------------------------------------------------
package ssc_pkg;

    localparam int COORD_W   = 16;
    localparam int RAD_W     = COORD_W - 1;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int RSUM_W    = RAD_W + 1;
    localparam int RR_W      = 2 * RSUM_W;
    localparam int DD_W      = 2 * DIFF_W;
    localparam int AA_W      = 2 * COORD_W;
    localparam int MAG_W     = DIFF_W + COORD_W;
    localparam int HU_W      = MAG_W + 1;
    localparam int DISC_W    = 2 * MAG_W;
    localparam int TR_W      = DISC_W + 1;
    localparam int ROOT_W    = MAG_W;
    localparam int FRAC_W    = 16;
    localparam int HITF_W    = FRAC_W + 1;
    localparam int VEC_W     = DIFF_W + FRAC_W + 1;
    localparam int VMAG_W    = VEC_W;
    localparam int VPOS_W    = 6;
    localparam int NM_W      = 16;
    localparam int NSQ_W     = 2 * NM_W;
    localparam int NSUM_W    = NSQ_W + 2;
    localparam int LSH       = 26;
    localparam int LX_W      = NSUM_W + LSH;
    localparam int LTR_W     = LX_W + 1;
    localparam int LEN_W     = LX_W / 2;
    localparam int NSH       = 27;
    localparam int ND_W      = NM_W + NSH + 1;
    localparam int NQ_W      = 15;
    localparam int NREM_W    = LEN_W + 1;
    localparam int NORM_W    = 16;
    localparam int QDEPTH    = 8;
    localparam int QPTR_W    = 3;
    localparam int QCNT_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [HITF_W-1:0] NO_HIT      = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [NQ_W-1:0]   UNIT_Q14    = {1'b1, {(NQ_W-1){1'b0}}};
    localparam logic [RAD_W-1:0]  OWN_R_RESET = RAD_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS
    } cfg_reg_e;

    // classified query, front to back
    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic signed [COORD_W-1:0] mz;
        logic [AA_W-1:0]           aa;
        logic [MAG_W-1:0]          mag;
        logic [DD_W-1:0]           cmr;
        logic                      overlap;
        logic                      same;
        logic                      nohit;
    } q_entry_t;

    // contact vector handed to the normal unit
    typedef struct packed {
        logic                      valid;
        logic [HITF_W-1:0]         hit_fraction;
        logic                      overlap;
        logic [2:0][VMAG_W-1:0]    mag;
        logic [2:0]                neg;
    } nrm_in_t;

    typedef struct packed {
        logic                      valid;
        logic [HITF_W-1:0]         hit_fraction;
        logic [2:0][NORM_W-1:0]    normal;
        logic                      overlap;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/swept_sphere_collision.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swept_sphere_collision
// First contact of a moving sphere against a fixed configured sphere.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  --------  ---------------------  -----------------------------------------
//  query     push / full            other_center_xyz, other_radius, move_xyz
//  result    empty / pop            hit_fraction, normal_xyz, overlap_at_start
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One query per cycle is taken while full is low, and one result per cycle is delivered while results are popped.
//  The path runs through 3 front stages, the queue, then a 33 stage
//  discriminant root, a 16 stage fraction divider, a 30 stage length root and
//  15 stage normal dividers, one bit per stage each.
//  A stalled result holds the whole back pipeline; the front keeps running
//  into an 8 entry queue and full rises once queue plus front is at 8.
//  Reset clears control state only; config registers reset to a unit sphere
//  (radius 1.0) at the origin.
//
module swept_sphere_collision import ssc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // query transfer
    input  logic                      push,
    output logic                      full,
    input  logic signed [COORD_W-1:0] other_center_x,
    input  logic signed [COORD_W-1:0] other_center_y,
    input  logic signed [COORD_W-1:0] other_center_z,
    input  logic [RAD_W-1:0]          other_radius,
    input  logic signed [COORD_W-1:0] move_x,
    input  logic signed [COORD_W-1:0] move_y,
    input  logic signed [COORD_W-1:0] move_z,
    // result transfer
    output logic                      empty,
    input  logic                      pop,
    output logic [HITF_W-1:0]         hit_fraction,
    output logic signed [NORM_W-1:0]  normal_x,
    output logic signed [NORM_W-1:0]  normal_y,
    output logic signed [NORM_W-1:0]  normal_z,
    output logic                      overlap_at_start,
    // config write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [COORD_W-1:0]        cfg_data
);

    logic signed [COORD_W-1:0] own_cx_reg;
    logic signed [COORD_W-1:0] own_cy_reg;
    logic signed [COORD_W-1:0] own_cz_reg;
    logic [RAD_W-1:0]          own_r_reg;

    logic              take;
    logic              adv;
    logic [1:0]        inflight;
    logic              ent_valid;
    q_entry_t          ent;
    logic              q_rvalid;
    q_entry_t          q_rdata;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W:0]   occupancy;
    nrm_in_t           nrm;
    result_t           res;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_cx_reg <= '0;
            own_cy_reg <= '0;
            own_cz_reg <= '0;
            own_r_reg  <= OWN_R_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_CENTER_X: own_cx_reg <= cfg_data;
                REG_CENTER_Y: own_cy_reg <= cfg_data;
                REG_CENTER_Z: own_cz_reg <= cfg_data;
                REG_RADIUS:   own_r_reg  <= cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // credit check: every query in the front lands in the queue
    assign occupancy = {1'b0, q_count} + (QCNT_W+1)'(inflight);
    assign full      = occupancy >= (QCNT_W+1)'(QDEPTH);
    assign take      = push && !full;

    // back pipeline advances whenever the result slot is free or drained
    assign adv   = !res.valid || pop;
    assign empty = !res.valid;

    ssc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .other_center_x (other_center_x),
        .other_center_y (other_center_y),
        .other_center_z (other_center_z),
        .other_radius   (other_radius),
        .move_x         (move_x),
        .move_y         (move_y),
        .move_z         (move_z),
        .own_cx         (own_cx_reg),
        .own_cy         (own_cy_reg),
        .own_cz         (own_cz_reg),
        .own_r          (own_r_reg),
        .inflight       (inflight),
        .ent_valid      (ent_valid),
        .ent            (ent)
    );

    ssc_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (ent_valid),
        .wdata  (ent),
        .rd     (adv && q_rvalid),
        .rvalid (q_rvalid),
        .rdata  (q_rdata),
        .count  (q_count)
    );

    ssc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (q_rvalid),
        .in_ent   (q_rdata),
        .nrm      (nrm)
    );

    ssc_normal u_normal
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .nin   (nrm),
        .res   (res)
    );

    assign hit_fraction     = res.hit_fraction;
    assign normal_x         = res.normal[0];
    assign normal_y         = res.normal[1];
    assign normal_z         = res.normal[2];
    assign overlap_at_start = res.overlap;

endmodule
`default_nettype wire

// File: rtl/ssc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_front
// Three stage front: differences, products, sums and classification.
// ----------------------------------------------------------------------------
module ssc_front import ssc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic signed [COORD_W-1:0] other_center_x,
    input  logic signed [COORD_W-1:0] other_center_y,
    input  logic signed [COORD_W-1:0] other_center_z,
    input  logic [RAD_W-1:0]          other_radius,
    input  logic signed [COORD_W-1:0] move_x,
    input  logic signed [COORD_W-1:0] move_y,
    input  logic signed [COORD_W-1:0] move_z,
    input  logic signed [COORD_W-1:0] own_cx,
    input  logic signed [COORD_W-1:0] own_cy,
    input  logic signed [COORD_W-1:0] own_cz,
    input  logic [RAD_W-1:0]          own_r,
    output logic [1:0]                inflight,
    output logic                      ent_valid,
    output q_entry_t                  ent
);

    logic [2:0]                v_reg;
    logic signed [DIFF_W-1:0]  d1_reg [3];
    logic signed [COORD_W-1:0] m1_reg [3];
    logic [RSUM_W-1:0]         rs1_reg;
    logic signed [DIFF_W-1:0]  d2_reg [3];
    logic signed [COORD_W-1:0] m2_reg [3];
    logic [DD_W-1:0]           pdd_reg [3];
    logic [AA_W-1:0]           paa_reg [3];
    logic signed [HU_W-1:0]    phu_reg [3];
    logic [RR_W-1:0]           rr_reg;
    q_entry_t                  ent_reg;

    logic signed [DIFF_W-1:0]  oc [3];
    logic signed [DIFF_W-1:0]  wc [3];
    logic signed [COORD_W-1:0] mi [3];
    logic signed [DD_W-1:0]    sqd_next [3];
    logic signed [AA_W-1:0]    sqm_next [3];
    logic signed [HU_W-1:0]    pdm_next [3];
    logic [RR_W-1:0]           rr_next;
    logic [DD_W-1:0]           dd_next;
    logic [AA_W-1:0]           aa_next;
    logic signed [HU_W-1:0]    hu_next;
    logic signed [HU_W-1:0]    nhu_next;
    logic [DD_W-1:0]           rrw;
    q_entry_t                  ent_next;

    assign oc[0] = other_center_x;
    assign oc[1] = other_center_y;
    assign oc[2] = other_center_z;
    assign wc[0] = own_cx;
    assign wc[1] = own_cy;
    assign wc[2] = own_cz;
    assign mi[0] = move_x;
    assign mi[1] = move_y;
    assign mi[2] = move_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqd_next[i] = d1_reg[i] * d1_reg[i];
            sqm_next[i] = m1_reg[i] * m1_reg[i];
            pdm_next[i] = d1_reg[i] * m1_reg[i];
        end
        rr_next = rs1_reg * rs1_reg;
    end

    always_comb
    begin
        dd_next  = pdd_reg[0] + pdd_reg[1] + pdd_reg[2];
        aa_next  = paa_reg[0] + paa_reg[1] + paa_reg[2];
        hu_next  = phu_reg[0] + phu_reg[1] + phu_reg[2];
        nhu_next = -hu_next;
        rrw      = DD_W'(rr_reg);
        ent_next.dx      = d2_reg[0];
        ent_next.dy      = d2_reg[1];
        ent_next.dz      = d2_reg[2];
        ent_next.mx      = m2_reg[0];
        ent_next.my      = m2_reg[1];
        ent_next.mz      = m2_reg[2];
        ent_next.aa      = aa_next;
        ent_next.mag     = nhu_next[MAG_W-1:0];
        ent_next.cmr     = dd_next - rrw;
        ent_next.overlap = dd_next <= rrw;
        ent_next.same    = dd_next == '0;
        // moving apart or standing still: no contact ahead
        ent_next.nohit   = !(dd_next <= rrw) && !hu_next[HU_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[1:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i] <= DIFF_W'(oc[i]) - DIFF_W'(wc[i]);
                m1_reg[i] <= mi[i];
            end
            rs1_reg <= RSUM_W'(other_radius) + RSUM_W'(own_r);
        end
        for (int i = 0; i < 3; i++)
        begin
            d2_reg[i]  <= d1_reg[i];
            m2_reg[i]  <= m1_reg[i];
            pdd_reg[i] <= sqd_next[i];
            paa_reg[i] <= sqm_next[i];
            phu_reg[i] <= pdm_next[i];
        end
        rr_reg  <= rr_next;
        ent_reg <= ent_next;
    end

    assign inflight  = 2'(v_reg[0]) + 2'(v_reg[1]) + 2'(v_reg[2]);
    assign ent_valid = v_reg[2];
    assign ent       = ent_reg;

endmodule
`default_nettype wire

// File: rtl/ssc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_queue
// Short queue of classified queries between front and back.
// ----------------------------------------------------------------------------
module ssc_queue import ssc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  q_entry_t          wdata,
    input  logic              rd,
    output logic              rvalid,
    output q_entry_t          rdata,
    output logic [QCNT_W-1:0] count
);

    q_entry_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg;
    logic [QPTR_W-1:0] rp_reg;
    logic [QCNT_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + QCNT_W'(wr) - QCNT_W'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    assign rvalid = cnt_reg != '0;
    assign rdata  = mem_reg[rp_reg];
    assign count  = cnt_reg;

endmodule
`default_nettype wire

// File: rtl/ssc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_back
// Discriminant, bit-per-stage square root, fraction divider, contact vector.
// ----------------------------------------------------------------------------
module ssc_back import ssc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  q_entry_t in_ent,
    output nrm_in_t  nrm
);

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic signed [COORD_W-1:0] mx;
        logic signed [COORD_W-1:0] my;
        logic signed [COORD_W-1:0] mz;
        logic [AA_W-1:0]           aa;
        logic [MAG_W-1:0]          mag;
        logic                      overlap;
        logic                      same;
        logic                      nohit;
    } side_t;

    side_t             in_side;
    logic              b1_v_reg;
    side_t             b1_side_reg;
    side_t             b1_side_chk;
    logic [DISC_W-1:0] bb_reg;
    logic [DISC_W-1:0] ac_reg;
    logic [DISC_W-1:0] bb_next;
    logic [DISC_W-1:0] ac_next;
    logic [DISC_W:0]   disc_next;

    logic              sq_v_reg    [0:ROOT_W];
    side_t             sq_side_reg [0:ROOT_W];
    logic [DISC_W-1:0] sq_rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [0:ROOT_W];

    logic              dv_v_reg    [0:FRAC_W];
    side_t             dv_side_reg [0:FRAC_W];
    logic [MAG_W-1:0]  dv_rem_reg  [0:FRAC_W];
    logic [FRAC_W-1:0] dv_q_reg    [0:FRAC_W];

    side_t             c_side;
    logic [ROOT_W-1:0] c_root;
    logic [MAG_W-1:0]  c_num;

    side_t                     v_side;
    logic [FRAC_W-1:0]         v_q;
    logic signed [DIFF_W-1:0]  ds [3];
    logic signed [COORD_W-1:0] ms [3];
    logic signed [VEC_W-1:0]   dw [3];
    logic signed [VEC_W-1:0]   mw [3];
    logic signed [VEC_W-1:0]   pw [3];
    logic signed [VEC_W-1:0]   vec [3];
    logic signed [FRAC_W:0]    qs;
    nrm_in_t                   nrm_next;
    logic                      nrm_v_reg;
    nrm_in_t                   nrm_reg;

    always_comb
    begin
        in_side.dx      = in_ent.dx;
        in_side.dy      = in_ent.dy;
        in_side.dz      = in_ent.dz;
        in_side.mx      = in_ent.mx;
        in_side.my      = in_ent.my;
        in_side.mz      = in_ent.mz;
        in_side.aa      = in_ent.aa;
        in_side.mag     = in_ent.mag;
        in_side.overlap = in_ent.overlap;
        in_side.same    = in_ent.same;
        in_side.nohit   = in_ent.nohit;
    end

    assign bb_next   = in_ent.mag * in_ent.mag;
    assign ac_next   = in_ent.aa * in_ent.cmr;
    assign disc_next = {1'b0, bb_reg} - {1'b0, ac_reg};

    // stage 1: squares of the half coefficient and a*c
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b1_v_reg <= 1'b0;
        else if (adv)
            b1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_side_reg <= in_side;
            bb_reg      <= bb_next;
            ac_reg      <= ac_next;
        end
    end

    // stage 2: discriminant, negative means no real root
    always_comb
    begin
        b1_side_chk       = b1_side_reg;
        b1_side_chk.nohit = b1_side_reg.nohit | disc_next[DISC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (adv)
            sq_v_reg[0] <= b1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_side_reg[0] <= b1_side_chk;
            sq_rem_reg[0]  <= disc_next[DISC_W-1:0];
            sq_root_reg[0] <= '0;
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [TR_W-1:0] trial;
        logic            fits;

        assign trial = (TR_W'(sq_root_reg[k]) << (B + 1)) | (TR_W'(1) << (2 * B));
        assign fits  = TR_W'(sq_rem_reg[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[k+1] <= 1'b0;
            else if (adv)
                sq_v_reg[k+1] <= sq_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_side_reg[k+1] <= sq_side_reg[k];
                sq_rem_reg[k+1]  <= fits ? sq_rem_reg[k] - trial[DISC_W-1:0]
                                         : sq_rem_reg[k];
                sq_root_reg[k+1] <= fits ? (sq_root_reg[k] | (ROOT_W'(1) << B))
                                         : sq_root_reg[k];
            end
        end
    end

    // root check and numerator of the fraction
    always_comb
    begin
        c_side = sq_side_reg[ROOT_W];
        c_root = sq_root_reg[ROOT_W];
        c_num  = c_side.mag - c_root;
        if (c_root >= c_side.mag || c_num >= MAG_W'(c_side.aa))
            c_side.nohit = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (adv)
            dv_v_reg[0] <= sq_v_reg[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_side_reg[0] <= c_side;
            dv_rem_reg[0]  <= c_num;
            dv_q_reg[0]    <= '0;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < FRAC_W; j++)
    begin : g_frac
        logic [MAG_W:0] r2;
        logic           ge;

        assign r2 = {dv_rem_reg[j], 1'b0};
        assign ge = r2 >= (MAG_W+1)'(dv_side_reg[j].aa);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else if (adv)
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_side_reg[j+1] <= dv_side_reg[j];
                dv_rem_reg[j+1]  <= ge ? MAG_W'(r2 - (MAG_W+1)'(dv_side_reg[j].aa))
                                       : r2[MAG_W-1:0];
                dv_q_reg[j+1]    <= {dv_q_reg[j][FRAC_W-2:0], ge};
            end
        end
    end

    // contact vector: diff*65536 + move*t, the overlap fallback, or zero on no hit
    always_comb
    begin
        v_side = dv_side_reg[FRAC_W];
        v_q    = dv_q_reg[FRAC_W];
        qs     = {1'b0, v_q};
        ds[0]  = v_side.dx;
        ds[1]  = v_side.dy;
        ds[2]  = v_side.dz;
        ms[0]  = v_side.mx;
        ms[1]  = v_side.my;
        ms[2]  = v_side.mz;
        nrm_next.valid   = dv_v_reg[FRAC_W];
        nrm_next.overlap = v_side.overlap;
        if (v_side.overlap)
            nrm_next.hit_fraction = '0;
        else if (v_side.nohit)
            nrm_next.hit_fraction = NO_HIT;
        else
            nrm_next.hit_fraction = {1'b0, v_q};
        for (int i = 0; i < 3; i++)
        begin
            dw[i] = ds[i];
            mw[i] = ms[i];
            pw[i] = ms[i] * qs;
            if (v_side.overlap)
                vec[i] = v_side.same ? -mw[i] : dw[i];
            else if (v_side.nohit)
                vec[i] = '0;
            else
                vec[i] = (dw[i] <<< FRAC_W) + pw[i];
            nrm_next.neg[i] = vec[i][VEC_W-1];
            nrm_next.mag[i] = vec[i][VEC_W-1] ? VMAG_W'(-vec[i]) : VMAG_W'(vec[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nrm_v_reg <= 1'b0;
        else if (adv)
            nrm_v_reg <= dv_v_reg[FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            nrm_reg <= nrm_next;
    end

    always_comb
    begin
        nrm       = nrm_reg;
        nrm.valid = nrm_v_reg;
    end

endmodule
`default_nettype wire

// File: rtl/ssc_normal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_normal
// Unit normal: normalize, sum of squares, root, three per-lane dividers.
// ----------------------------------------------------------------------------
module ssc_normal import ssc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  nrm_in_t nin,
    output result_t res
);

    typedef struct packed {
        logic [HITF_W-1:0] hf;
        logic              overlap;
        logic [2:0]        neg;
        logic              zero;
    } nside_t;

    // N1: leading one of the largest magnitude
    logic [VMAG_W-1:0] mx;
    logic [VPOS_W-1:0] pos_next;
    logic              n1_v_reg;
    nside_t            n1_side_reg;
    logic [VMAG_W-1:0] n1_mag_reg [3];
    logic [VPOS_W-1:0] n1_pos_reg;

    // N2: shifted to 16 bits
    logic [VMAG_W-1:0] shv [3];
    logic              n2_v_reg;
    nside_t            n2_side_reg;
    logic [NM_W-1:0]   n2_m_reg [3];

    // N3: squares
    logic              n3_v_reg;
    nside_t            n3_side_reg;
    logic [NM_W-1:0]   n3_m_reg [3];
    logic [NSQ_W-1:0]  n3_sq_reg [3];
    logic [NSUM_W-1:0] ssum;

    // length root
    logic              ls_v_reg    [0:LEN_W];
    nside_t            ls_side_reg [0:LEN_W];
    logic [NM_W-1:0]   ls_m_reg    [0:LEN_W][3];
    logic [LX_W-1:0]   ls_rem_reg  [0:LEN_W];
    logic [LEN_W-1:0]  ls_root_reg [0:LEN_W];

    // dividers
    logic [ND_W-1:0]   dnum [3];
    logic              nd_v_reg    [0:NQ_W];
    nside_t            nd_side_reg [0:NQ_W];
    logic [LEN_W-1:0]  nd_len_reg  [0:NQ_W];
    logic [NREM_W-1:0] nd_rem_reg  [0:NQ_W][3];
    logic [NQ_W-1:0]   nd_low_reg  [0:NQ_W][3];
    logic [NQ_W-1:0]   nd_q_reg    [0:NQ_W][3];

    logic [NQ_W-1:0]   fin_n [3];
    logic [NORM_W-1:0] fin_u [3];
    logic [NORM_W-1:0] fin_o [3];
    logic              res_v_reg;
    result_t           res_reg;
    result_t           res_next;

    always_comb
    begin
        mx = nin.mag[0];
        if (nin.mag[1] > mx)
            mx = nin.mag[1];
        if (nin.mag[2] > mx)
            mx = nin.mag[2];
        pos_next = '0;
        for (int i = 0; i < VMAG_W; i++)
        begin
            if (mx[i])
                pos_next = VPOS_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n1_v_reg <= 1'b0;
            n2_v_reg <= 1'b0;
            n3_v_reg <= 1'b0;
            ls_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            n1_v_reg <= nin.valid;
            n2_v_reg <= n1_v_reg;
            n3_v_reg <= n2_v_reg;
            ls_v_reg[0] <= n3_v_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (n1_pos_reg >= VPOS_W'(NM_W))
                shv[i] = n1_mag_reg[i] >> (n1_pos_reg - VPOS_W'(NM_W - 1));
            else
                shv[i] = n1_mag_reg[i] << (VPOS_W'(NM_W - 1) - n1_pos_reg);
        end
        ssum = NSUM_W'(n3_sq_reg[0]) + NSUM_W'(n3_sq_reg[1]) + NSUM_W'(n3_sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_side_reg.hf      <= nin.hit_fraction;
            n1_side_reg.overlap <= nin.overlap;
            n1_side_reg.neg     <= nin.neg;
            n1_side_reg.zero    <= mx == '0;
            n1_pos_reg          <= pos_next;
            n2_side_reg         <= n1_side_reg;
            n3_side_reg         <= n2_side_reg;
            ls_side_reg[0]      <= n3_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                n1_mag_reg[i]  <= nin.mag[i];
                n2_m_reg[i]    <= shv[i][NM_W-1:0];
                n3_m_reg[i]    <= n2_m_reg[i];
                n3_sq_reg[i]   <= n2_m_reg[i] * n2_m_reg[i];
                ls_m_reg[0][i] <= n3_m_reg[i];
            end
            ls_rem_reg[0]  <= {ssum, {LSH{1'b0}}};
            ls_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < LEN_W; k++)
    begin : g_len
        localparam int B = LEN_W - 1 - k;
        logic [LTR_W-1:0] trial;
        logic             fits;

        assign trial = (LTR_W'(ls_root_reg[k]) << (B + 1)) | (LTR_W'(1) << (2 * B));
        assign fits  = LTR_W'(ls_rem_reg[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                ls_v_reg[k+1] <= 1'b0;
            else if (adv)
                ls_v_reg[k+1] <= ls_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ls_side_reg[k+1] <= ls_side_reg[k];
                ls_m_reg[k+1]    <= ls_m_reg[k];
                ls_rem_reg[k+1]  <= fits ? ls_rem_reg[k] - trial[LX_W-1:0] : ls_rem_reg[k];
                ls_root_reg[k+1] <= fits ? (ls_root_reg[k] | (LEN_W'(1) << B))
                                         : ls_root_reg[k];
            end
        end
    end

    // rounded dividend m*2^27 + len/2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dnum[i] = {1'b0, ls_m_reg[LEN_W][i], {NSH{1'b0}}}
                      + ND_W'(ls_root_reg[LEN_W] >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nd_v_reg[0] <= 1'b0;
        else if (adv)
            nd_v_reg[0] <= ls_v_reg[LEN_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nd_side_reg[0] <= ls_side_reg[LEN_W];
            nd_len_reg[0]  <= ls_root_reg[LEN_W];
            for (int i = 0; i < 3; i++)
            begin
                nd_rem_reg[0][i] <= NREM_W'(dnum[i][ND_W-1:NQ_W]);
                nd_low_reg[0][i] <= dnum[i][NQ_W-1:0];
                nd_q_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar j = 0; j < NQ_W; j++)
    begin : g_div
        logic [NREM_W-1:0] r2 [3];
        logic [2:0]        ge;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                r2[l] = {nd_rem_reg[j][l][NREM_W-2:0], nd_low_reg[j][l][NQ_W-1-j]};
                ge[l] = r2[l] >= NREM_W'(nd_len_reg[j]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                nd_v_reg[j+1] <= 1'b0;
            else if (adv)
                nd_v_reg[j+1] <= nd_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nd_side_reg[j+1] <= nd_side_reg[j];
                nd_len_reg[j+1]  <= nd_len_reg[j];
                nd_low_reg[j+1]  <= nd_low_reg[j];
                for (int l = 0; l < 3; l++)
                begin
                    nd_rem_reg[j+1][l] <= ge[l] ? r2[l] - NREM_W'(nd_len_reg[j]) : r2[l];
                    nd_q_reg[j+1][l]   <= {nd_q_reg[j][l][NQ_W-2:0], ge[l]};
                end
            end
        end
    end

    // cap, zero vector, sign
    always_comb
    begin
        res_next.valid        = nd_v_reg[NQ_W];
        res_next.hit_fraction = nd_side_reg[NQ_W].hf;
        res_next.overlap      = nd_side_reg[NQ_W].overlap;
        for (int i = 0; i < 3; i++)
        begin
            fin_n[i] = nd_q_reg[NQ_W][i];
            if (fin_n[i] > UNIT_Q14)
                fin_n[i] = UNIT_Q14;
            if (nd_side_reg[NQ_W].zero)
                fin_n[i] = '0;
            fin_u[i] = NORM_W'(fin_n[i]);
            fin_o[i] = nd_side_reg[NQ_W].neg[i] ? -fin_u[i] : fin_u[i];
            res_next.normal[i] = fin_o[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_v_reg <= 1'b0;
        else if (adv)
            res_v_reg <= nd_v_reg[NQ_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= res_next;
    end

    always_comb
    begin
        res       = res_reg;
        res.valid = res_v_reg;
    end

endmodule
`default_nettype wire
